// ===== rtl/mctw_pkg.sv =====
package mctw_pkg;

    // table geometry
    localparam int MAX_CH = 16;
    localparam int IDX_W  = (MAX_CH > 1) ? $clog2(MAX_CH) : 1;
    localparam int CNT_W  = $clog2(MAX_CH + 1);

    // field widths
    localparam int ACT_W      = 2;
    localparam int TASK_W     = 8;
    localparam int TMO_W      = 32;
    localparam int INTV_W     = 16;
    localparam int STAT_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // register reset values, tick interval is 2 s
    localparam logic [INTV_W-1:0] TICK_INTV_RESET = INTV_W'(2 * 1000);
    localparam logic              SUP_EN_RESET    = 1'b1;
    localparam logic              COMMON_RESET    = 1'b0;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TICK_INTV = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SUP_EN    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COMMON    = 2'd2;

    // actions
    localparam logic [ACT_W-1:0] ACT_TICK   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_ADD    = 2'd1;
    localparam logic [ACT_W-1:0] ACT_FEED   = 2'd2;
    localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd3;

    // result status
    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_NO_CHAN = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL    = 2'd2;
    localparam logic [STAT_W-1:0] ST_ZERO_TO = 2'd3;

    // datapath operations
    localparam int OP_W = 4;
    typedef logic [OP_W-1:0] op_t;
    localparam op_t OP_NOP      = 4'd0;
    localparam op_t OP_LOAD     = 4'd1;  // latch request, clear result, idx = 0
    localparam op_t OP_ADD      = 4'd2;  // append channel or flag error
    localparam op_t OP_TICK     = 4'd3;  // service channel idx, idx++
    localparam op_t OP_INC      = 4'd4;  // idx++
    localparam op_t OP_ARM      = 4'd5;  // arm channel idx, clear counter
    localparam op_t OP_SHIFT    = 4'd6;  // move channel idx down one, idx++
    localparam op_t OP_DEC      = 4'd7;  // drop last channel
    localparam op_t OP_NOTFOUND = 4'd8;  // status = no channel
    localparam op_t OP_OUT      = 4'd9;  // copy result into output register

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic             enable;
        logic             cnt_zero;
        logic             hit;       // channel idx belongs to the task
        logic             expire;    // channel idx ran out
        logic             idx_last;  // idx is the last channel
        logic             idx_end;   // idx is past the last channel
        logic             out_free;
    } status_t;

endpackage

// ===== rtl/mctw_if.sv =====
interface mctw_req_if import mctw_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [ACT_W-1:0]  action;
    logic [TASK_W-1:0] task_id;
    logic [TMO_W-1:0]  timeout_ms;
    logic              has_own_handler;

    modport source (output valid, action, task_id, timeout_ms, has_own_handler,
                    input ready);
    modport sink   (input valid, action, task_id, timeout_ms, has_own_handler,
                    output ready);
endinterface

interface mctw_rsp_if import mctw_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic              expired;
    logic [TASK_W-1:0] expired_task;
    logic              use_own_handler;
    logic              handler_called;

    modport source (output valid, status, expired, expired_task, use_own_handler,
                    handler_called, input ready);
    modport sink   (input valid, status, expired, expired_task, use_own_handler,
                    handler_called, output ready);
endinterface

interface mctw_cfg_if import mctw_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/mctw_ctrl.sv =====
module mctw_ctrl import mctw_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    req_valid,
    output logic    req_ready,
    input  status_t st,
    output cmd_t    cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_TICK   = 3'd2;
    localparam logic [2:0] S_FIND   = 3'd3;
    localparam logic [2:0] S_SHIFT  = 3'd4;
    localparam logic [2:0] S_DONE   = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign req_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = OP_NOP;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                case (st.action)
                    ACT_TICK:
                    begin
                        if (!st.enable || st.cnt_zero)
                            state_next = S_DONE;
                        else
                            state_next = S_TICK;
                    end
                    ACT_ADD:
                    begin
                        cmd.op     = OP_ADD;
                        state_next = S_DONE;
                    end
                    default:
                    begin
                        if (st.cnt_zero)
                        begin
                            cmd.op     = OP_NOTFOUND;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            state_next = S_FIND;
                        end
                    end
                endcase
            end
            S_TICK:
            begin
                cmd.op = OP_TICK;
                if (st.expire || st.idx_last)
                    state_next = S_DONE;
            end
            S_FIND:
            begin
                if (st.hit)
                begin
                    if (st.action inside {ACT_FEED})
                    begin
                        cmd.op     = OP_ARM;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        // idx now points at the first channel to move down
                        cmd.op     = OP_INC;
                        state_next = S_SHIFT;
                    end
                end
                else if (st.idx_last)
                begin
                    cmd.op     = OP_NOTFOUND;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.op = OP_INC;
                end
            end
            S_SHIFT:
            begin
                if (st.idx_end)
                begin
                    cmd.op     = OP_DEC;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.op = OP_SHIFT;
                end
            end
            S_DONE:
            begin
                if (st.out_free)
                begin
                    cmd.op     = OP_OUT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// ===== rtl/mctw_dp.sv =====
module mctw_dp import mctw_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  cmd_t              cmd,
    output status_t           st,
    input  logic [ACT_W-1:0]  action,
    input  logic [TASK_W-1:0] task_id,
    input  logic [TMO_W-1:0]  timeout_ms,
    input  logic              has_own_handler,
    mctw_cfg_if.sink          cfg,
    mctw_rsp_if.source        rsp
);

    // channel table
    logic [TASK_W-1:0] tab_task_reg    [MAX_CH];
    logic [TMO_W-1:0]  tab_tmo_reg     [MAX_CH];
    logic [TMO_W-1:0]  tab_elapsed_reg [MAX_CH];
    logic              tab_own_reg     [MAX_CH];
    logic              tab_armed_reg   [MAX_CH];
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  idx_reg;

    // configuration
    logic [INTV_W-1:0] intv_reg;
    logic              sup_en_reg;
    logic              common_reg;

    // request being worked on
    logic [ACT_W-1:0]  act_reg;
    logic [TASK_W-1:0] task_reg;
    logic [TMO_W-1:0]  tmo_reg;
    logic              own_reg;

    // result under construction and output register
    logic [STAT_W-1:0] res_status_reg;
    logic              res_expired_reg;
    logic [TASK_W-1:0] res_task_reg;
    logic              res_own_reg;
    logic              res_called_reg;
    logic              out_valid_reg;
    logic [STAT_W-1:0] out_status_reg;
    logic              out_expired_reg;
    logic [TASK_W-1:0] out_task_reg;
    logic              out_own_reg;
    logic              out_called_reg;

    logic [IDX_W-1:0]  rd_idx;
    logic [CNT_W-1:0]  idx_dec;
    logic [IDX_W-1:0]  wr_shift;
    logic [IDX_W-1:0]  wr_add;
    logic [TASK_W-1:0] rd_task;
    logic [TMO_W-1:0]  rd_tmo;
    logic [TMO_W-1:0]  rd_elapsed;
    logic              rd_own;
    logic              rd_armed;
    logic              eligible;
    logic              expire;
    logic [TMO_W:0]    sum;
    logic [TMO_W-1:0]  sat_sum;
    logic              add_ok;

    assign rd_idx     = idx_reg[IDX_W-1:0];
    assign idx_dec    = idx_reg - CNT_W'(1);
    assign wr_shift   = idx_dec[IDX_W-1:0];
    assign wr_add     = cnt_reg[IDX_W-1:0];
    assign rd_task    = tab_task_reg[rd_idx];
    assign rd_tmo     = tab_tmo_reg[rd_idx];
    assign rd_elapsed = tab_elapsed_reg[rd_idx];
    assign rd_own     = tab_own_reg[rd_idx];
    assign rd_armed   = tab_armed_reg[rd_idx];

    // zero-timeout channels are never serviced
    assign eligible = rd_armed && (rd_tmo != '0);
    assign expire   = eligible && (rd_tmo <= rd_elapsed);
    assign sum      = {1'b0, rd_elapsed} + (TMO_W + 1)'(intv_reg);
    assign sat_sum  = sum[TMO_W] ? '1 : sum[TMO_W-1:0];
    assign add_ok   = (tmo_reg != '0) && (cnt_reg != CNT_W'(MAX_CH));

    assign st.action   = act_reg;
    assign st.enable   = sup_en_reg;
    assign st.cnt_zero = (cnt_reg == '0);
    assign st.hit      = (rd_task == task_reg);
    assign st.expire   = expire;
    assign st.idx_last = ({1'b0, idx_reg} + (CNT_W + 1)'(1)) >= {1'b0, cnt_reg};
    assign st.idx_end  = (idx_reg >= cnt_reg);
    assign st.out_free = !out_valid_reg || rsp.ready;

    assign cfg.ready = 1'b1;

    assign rsp.valid           = out_valid_reg;
    assign rsp.status          = out_status_reg;
    assign rsp.expired         = out_expired_reg;
    assign rsp.expired_task    = out_task_reg;
    assign rsp.use_own_handler = out_own_reg;
    assign rsp.handler_called  = out_called_reg;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
            intv_reg      <= TICK_INTV_RESET;
            sup_en_reg    <= SUP_EN_RESET;
            common_reg    <= COMMON_RESET;
            for (int i = 0; i < MAX_CH; i++)
                tab_armed_reg[i] <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                case (cfg.index)
                    CFG_TICK_INTV: intv_reg   <= cfg.data[INTV_W-1:0];
                    CFG_SUP_EN:    sup_en_reg <= cfg.data[0];
                    CFG_COMMON:    common_reg <= cfg.data[0];
                    default:       ;
                endcase
            end

            if (cmd.op == OP_OUT)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;

            case (cmd.op)
                OP_LOAD:
                begin
                    idx_reg <= '0;
                end
                OP_ADD:
                begin
                    if (add_ok)
                    begin
                        tab_armed_reg[wr_add] <= 1'b0;
                        cnt_reg               <= cnt_reg + CNT_W'(1);
                    end
                end
                OP_TICK, OP_INC:
                begin
                    idx_reg <= idx_reg + CNT_W'(1);
                end
                OP_ARM:
                begin
                    tab_armed_reg[rd_idx] <= 1'b1;
                end
                OP_SHIFT:
                begin
                    tab_armed_reg[wr_shift] <= rd_armed;
                    idx_reg                 <= idx_reg + CNT_W'(1);
                end
                OP_DEC:
                begin
                    cnt_reg <= cnt_reg - CNT_W'(1);
                end
                default: ;
            endcase
        end
    end

    // table payload and result words
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                act_reg         <= action;
                task_reg        <= task_id;
                tmo_reg         <= timeout_ms;
                own_reg         <= has_own_handler;
                res_status_reg  <= ST_OK;
                res_expired_reg <= 1'b0;
                res_task_reg    <= '0;
                res_own_reg     <= 1'b0;
                res_called_reg  <= 1'b0;
            end
            OP_ADD:
            begin
                if (tmo_reg == '0)
                begin
                    res_status_reg <= ST_ZERO_TO;
                end
                else if (!add_ok)
                begin
                    res_status_reg <= ST_FULL;
                end
                else
                begin
                    tab_task_reg[wr_add]    <= task_reg;
                    tab_tmo_reg[wr_add]     <= tmo_reg;
                    tab_elapsed_reg[wr_add] <= '0;
                    tab_own_reg[wr_add]     <= own_reg;
                end
            end
            OP_TICK:
            begin
                if (expire)
                begin
                    tab_elapsed_reg[rd_idx] <= '0;
                    res_expired_reg         <= 1'b1;
                    res_task_reg            <= rd_task;
                    res_own_reg             <= rd_own;
                    res_called_reg          <= rd_own || common_reg;
                end
                else if (eligible)
                begin
                    tab_elapsed_reg[rd_idx] <= sat_sum;
                end
            end
            OP_ARM:
            begin
                tab_elapsed_reg[rd_idx] <= '0;
            end
            OP_SHIFT:
            begin
                tab_task_reg[wr_shift]    <= rd_task;
                tab_tmo_reg[wr_shift]     <= rd_tmo;
                tab_elapsed_reg[wr_shift] <= rd_elapsed;
                tab_own_reg[wr_shift]     <= rd_own;
            end
            OP_NOTFOUND:
            begin
                res_status_reg <= ST_NO_CHAN;
            end
            OP_OUT:
            begin
                out_status_reg  <= res_status_reg;
                out_expired_reg <= res_expired_reg;
                out_task_reg    <= res_task_reg;
                out_own_reg     <= res_own_reg;
                out_called_reg  <= res_called_reg;
            end
            default: ;
        endcase
    end

endmodule

// ===== rtl/multi_channel_task_watchdog_core.sv =====
// Watchdog table for up to MAX_CH software task channels, kept in the order
// they were added. One request word (tick, add, feed, remove) is worked on at
// a time and always yields exactly one response word. An add needs no table
// walk; a tick walks the channels up to the first expiry or the last channel,
// a feed walks them up to the matching task, and a remove searches for the
// task and then closes the gap. The walks step the table one entry per cycle
// through a single read port. A new request is taken as soon as the previous
// response sits in the output register, even if it is not yet consumed.
// Config writes are always ready and should only be issued while no request
// is in flight.
module multi_channel_task_watchdog_core import mctw_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    mctw_req_if.sink    req,
    mctw_rsp_if.source  rsp,
    mctw_cfg_if.sink    cfg
);

    cmd_t    cmd;     // controller -> datapath
    status_t st;      // datapath -> controller
    logic    ready;

    assign req.ready = ready;

    // Sequencer: decodes the request, steps the table walk, hands off result.
    mctw_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (ready),
        .st        (st),
        .cmd       (cmd)
    );

    // Table, config registers, result and output registers.
    mctw_dp u_dp
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .st              (st),
        .action          (req.action),
        .task_id         (req.task_id),
        .timeout_ms      (req.timeout_ms),
        .has_own_handler (req.has_own_handler),
        .cfg             (cfg),
        .rsp             (rsp)
    );

    // one request in flight: ready drops right after an accept
    ap_single_item: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("request accepted while another was in flight");

    // own handler is only reported on an expiry, and then a handler runs
    ap_own_handler: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.use_own_handler) |-> (rsp.expired && rsp.handler_called))
        else $error("own handler flagged without expiry or call");

    // expiries come only from ticks, which always report ok
    ap_expiry_status: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.expired) |-> (rsp.status == ST_OK))
        else $error("expiry reported with error status");

endmodule
